// ===== rtl/crt_pkg.sv =====
// Shared constants and types for the three-moduli CRT block.
package crt_pkg;

  localparam int unsigned MOD_BITS_DEF = 21;
  localparam int unsigned VAL_BITS = 63;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS_0 = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS_1 = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MODULUS_2 = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_INVERSE = 1'b1;

  // Lane status (done, fail) passed to the merge stage.
  typedef struct packed {
    logic done;
    logic fail;
  } lane_stat_t;

endpackage

// ===== rtl/crt_if.sv =====
// Valid/ready channel interfaces for the CRT block.
interface crt_in_if #(parameter int unsigned MOD_BITS = crt_pkg::MOD_BITS_DEF);
  logic                valid;
  logic                ready;
  logic [MOD_BITS-1:0] residue_0;
  logic [MOD_BITS-1:0] residue_1;
  logic [MOD_BITS-1:0] residue_2;
  modport source (output valid, residue_0, residue_1, residue_2, input ready);
  modport sink (input valid, residue_0, residue_1, residue_2, output ready);
endinterface

interface crt_out_if;
  logic                          valid;
  logic                          ready;
  logic [crt_pkg::VAL_BITS-1:0]  combined_value;
  logic                          status;
  modport source (output valid, combined_value, status, input ready);
  modport sink (input valid, combined_value, status, output ready);
endinterface

interface crt_cfg_if #(parameter int unsigned MOD_BITS = crt_pkg::MOD_BITS_DEF);
  logic                               valid;
  logic                               ready;
  logic [crt_pkg::REG_IDX_BITS-1:0]   index;
  logic [MOD_BITS-1:0]                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/crt_divider.sv =====
// Restoring bit-serial divider: quotient and remainder of a by b.
module crt_divider #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;

  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  // One quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        quo  <= a;
        rem  <= '0;
        dvs  <= b;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/crt_lane.sv =====
// One CRT lane: cofactor, inverse by extended Euclid, and weighted term.
module crt_lane #(
  parameter int unsigned MOD_BITS = crt_pkg::MOD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [3*MOD_BITS-1:0]        prod,
  input  logic [MOD_BITS-1:0]          modulus,
  input  logic [MOD_BITS-1:0]          residue,
  output crt_pkg::lane_stat_t          stat,
  output logic [3*MOD_BITS-1:0]        term
);
  localparam int unsigned PW = 3 * MOD_BITS;
  localparam int unsigned SW = MOD_BITS + 2;
  localparam int unsigned LW = (PW + 1) / 2;
  localparam int unsigned HW = PW - LW;

  typedef enum logic [3:0] {
    S_IDLE, S_COF, S_CMOD, S_EUC, S_STEP, S_FIX, S_RED, S_KMUL, S_KRED, S_TERM,
    S_TLO, S_THI
  } st_t;

  st_t                  st;
  logic                 dv_start;
  logic [PW-1:0]        dv_a, dv_b, dv_q, dv_r;
  logic                 dv_done;
  logic [PW-1:0]        cof;
  logic [MOD_BITS-1:0]  pr, cr, rr;
  logic signed [SW-1:0] ps, cs;
  logic [2*MOD_BITS-1:0] prodk;
  logic [MOD_BITS-1:0]  qv, inv;
  logic [MOD_BITS-1:0]  kv;
  logic [LW+MOD_BITS-1:0] tpart;

  crt_divider #(.W(PW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .a(dv_a), .b(dv_b),
    .done(dv_done), .quo(dv_q), .rem(dv_r)
  );

  // k * cofactor in two halves of the cofactor, one half per cycle
  assign tpart = ((st == S_THI) ? LW'(cof[PW-1:LW]) : cof[LW-1:0]) * kv;

  // Euclid control; the divider is shared across all divisions of the lane
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      dv_start <= 1'b0;
      stat     <= '0;
    end else begin
      dv_start <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            stat     <= '0;
            dv_a     <= prod;
            dv_b     <= PW'(modulus);
            dv_start <= 1'b1;
            st       <= S_COF;
          end
        end
        S_COF: begin
          if (dv_done) begin
            cof      <= dv_q;
            dv_a     <= dv_q;
            dv_start <= 1'b1;
            st       <= S_CMOD;
          end
        end
        S_CMOD: begin
          if (dv_done) begin
            pr <= dv_r[MOD_BITS-1:0];
            cr <= modulus;
            ps <= SW'(1);
            cs <= '0;
            st <= S_EUC;
          end
        end
        S_EUC: begin
          if (cr == '0) begin
            st <= S_FIX;
          end else begin
            dv_a     <= PW'(pr);
            dv_b     <= PW'(cr);
            dv_start <= 1'b1;
            st       <= S_STEP;
          end
        end
        S_STEP: begin
          if (dv_done) begin
            qv <= dv_q[MOD_BITS-1:0];
            pr <= cr;
            cr <= dv_r[MOD_BITS-1:0];
            st <= S_RED;
          end
        end
        S_RED: begin
          // s update: ps - q * cs (q and cs bounded by the modulus)
          ps <= cs;
          cs <= SW'(ps - SW'(signed'({1'b0, qv}) * cs));
          st <= S_EUC;
        end
        S_FIX: begin
          if (pr != MOD_BITS'(1)) begin
            stat <= '{done: 1'b1, fail: 1'b1};
            term <= '0;
            st   <= S_IDLE;
          end else begin
            if (modulus == MOD_BITS'(1)) inv <= '0;
            else if (ps < 0) inv <= MOD_BITS'(ps + SW'({2'b0, modulus}));
            else inv <= ps[MOD_BITS-1:0];
            dv_a     <= PW'(residue);
            dv_b     <= PW'(modulus);
            dv_start <= 1'b1;
            st       <= S_KMUL;
          end
        end
        S_KMUL: begin
          if (dv_done) begin
            rr <= dv_r[MOD_BITS-1:0];
            st <= S_KRED;
            prodk <= '0;
          end
        end
        S_KRED: begin
          if (prodk == '0) begin
            prodk <= rr * inv;
          end else begin
            prodk    <= '0;
            dv_a     <= PW'(prodk);
            dv_start <= 1'b1;
            st       <= S_TERM;
          end
          if (rr == '0 || inv == '0) begin
            term <= '0;
            stat <= '{done: 1'b1, fail: 1'b0};
            st   <= S_IDLE;
            dv_start <= 1'b0;
          end
        end
        S_TERM: begin
          if (dv_done) begin
            kv <= dv_r[MOD_BITS-1:0];
            st <= S_TLO;
          end
        end
        S_TLO: begin
          term <= PW'(tpart);
          st   <= S_THI;
        end
        S_THI: begin
          term <= term + {tpart[HW-1:0], {LW{1'b0}}};
          stat <= '{done: 1'b1, fail: 1'b0};
          st   <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    dv_start |=> !dv_start) else $error("divider restarted");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> st == S_IDLE) else $error("lane started while busy");
  a_inv_range: assert property (@(posedge clk) disable iff (rst)
    st == S_KMUL |-> inv < modulus || modulus == MOD_BITS'(1))
    else $error("inverse out of range");
`endif
endmodule

// ===== rtl/crt_three_moduli.sv =====
// Top level of the three-moduli CRT reconstruction block.
// One word is processed at a time. Three lanes run in parallel, each with its
// own bit-serial divider (one quotient bit per cycle) which forms the cofactor,
// its residue, the reduced input residue, every Euclid quotient and the final
// reduction; Euclid takes up to 30 steps for 21-bit moduli. A zero modulus
// skips the lanes and answers with the no-inverse status. The result register
// holds the answer until taken, and no word or register write is accepted
// before then. A register write wins over a word offered in the same cycle.
module crt_three_moduli #(
  parameter int unsigned MOD_BITS = crt_pkg::MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  crt_cfg_if.sink              cfg,
  crt_in_if.sink               in_ch,
  crt_out_if.source            out_ch
);
  localparam int unsigned PW = 3 * MOD_BITS;

  typedef enum logic [2:0] {
    T_IDLE, T_PROD, T_PROD2, T_LANE, T_SUM0, T_SUM1, T_OUT
  } tst_t;

  tst_t                 st;
  logic [MOD_BITS-1:0]  modulus [crt_pkg::NUM_LANES];
  logic [MOD_BITS-1:0]  res [crt_pkg::NUM_LANES];
  logic [PW-1:0]        prod, sum;
  logic [2*MOD_BITS-1:0] p01;
  logic [2*MOD_BITS-1:0] pp;
  logic                 lane_start;
  crt_pkg::lane_stat_t  lstat [crt_pkg::NUM_LANES];
  logic [PW-1:0]        lterm [crt_pkg::NUM_LANES];
  logic [1:0]           k;
  logic [PW:0]          acc;
  logic                 zero_mod;

  assign cfg.ready = (st == T_IDLE);
  assign in_ch.ready = (st == T_IDLE) && !cfg.valid;
  assign zero_mod = (modulus[0] == '0) || (modulus[1] == '0) || (modulus[2] == '0);
  assign acc = {1'b0, sum} + {1'b0, lterm[k]};

  // Partial product of the full product, low half of p01 first
  assign pp = ((st == T_PROD2) ? p01[2*MOD_BITS-1:MOD_BITS] : p01[MOD_BITS-1:0])
              * modulus[2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus[0] <= MOD_BITS'(1);
      modulus[1] <= MOD_BITS'(1);
      modulus[2] <= MOD_BITS'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        crt_pkg::REG_MODULUS_0: modulus[0] <= cfg.data;
        crt_pkg::REG_MODULUS_1: modulus[1] <= cfg.data;
        crt_pkg::REG_MODULUS_2: modulus[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      crt_lane #(.MOD_BITS(MOD_BITS)) u_lane (
        .clk(clk), .rst(rst), .start(lane_start), .prod(prod),
        .modulus(modulus[g]), .residue(res[g]), .stat(lstat[g]), .term(lterm[g])
      );
    end
  endgenerate

  // Sequencer and merge: product, lanes, modular sum, output
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= T_IDLE;
      lane_start   <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      lane_start <= 1'b0;
      case (st)
        T_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            res[0] <= in_ch.residue_0;
            res[1] <= in_ch.residue_1;
            res[2] <= in_ch.residue_2;
            p01    <= modulus[0] * modulus[1];
            if (zero_mod) begin
              out_ch.combined_value <= '0;
              out_ch.status         <= crt_pkg::STATUS_NO_INVERSE;
              out_ch.valid          <= 1'b1;
              st                    <= T_OUT;
            end else begin
              st <= T_PROD;
            end
          end
        end
        T_PROD: begin
          prod <= PW'(pp);
          st   <= T_PROD2;
        end
        T_PROD2: begin
          prod       <= prod + {pp, {MOD_BITS{1'b0}}};
          lane_start <= 1'b1;
          st         <= T_LANE;
        end
        T_LANE: begin
          if (!lane_start && lstat[0].done && lstat[1].done && lstat[2].done) begin
            if (lstat[0].fail || lstat[1].fail || lstat[2].fail) begin
              out_ch.combined_value <= '0;
              out_ch.status         <= crt_pkg::STATUS_NO_INVERSE;
              out_ch.valid          <= 1'b1;
              st                    <= T_OUT;
            end else begin
              sum <= '0;
              k   <= '0;
              st  <= T_SUM0;
            end
          end
        end
        T_SUM0: begin
          sum <= (acc >= {1'b0, prod}) ? PW'(acc - {1'b0, prod}) : acc[PW-1:0];
          if (k == 2'd2) st <= T_SUM1;
          else k <= k + 1'b1;
        end
        T_SUM1: begin
          out_ch.combined_value <= crt_pkg::VAL_BITS'(sum);
          out_ch.status         <= crt_pkg::STATUS_OK;
          out_ch.valid          <= 1'b1;
          st                    <= T_OUT;
        end
        T_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            st           <= T_IDLE;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> st == T_OUT) else $error("result shown outside output state");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status |-> out_ch.combined_value == '0)
    else $error("error word carries a value");
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    st == T_SUM1 |-> sum < prod) else $error("sum not reduced");
`endif
endmodule
